// ===== design/swl_pkg.sv =====
// Shared types and constants for the sliding window lifetime block.
// Used by swl_div_stage, swl_post, sliding_window_lifetime and tb_top; no dependencies.
`default_nettype none
package swl_pkg;

   localparam int TIME_W    = 64;
   localparam int RANGE_W   = 62;
   localparam int DIFF_W    = 66;
   localparam int MAG_W     = 65;
   localparam int REM_W     = 62;
   localparam int WIDE_W    = 67;
   localparam int IDX_OUT_W = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [RANGE_W-1:0] RANGE_RESET = 62'd1000000;
   localparam logic [RANGE_W-1:0] SLIDE_RESET = 62'd1000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START = 2'd0,
      CSR_RANGE = 2'd1,
      CSR_SLIDE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                     valid;
      logic signed [TIME_W-1:0] t;
      logic                     neg1;
      logic                     neg2;
      logic [MAG_W-1:0]         mag1;
      logic [MAG_W-1:0]         mag2;
      logic [MAG_W-1:0]         q1;
      logic [MAG_W-1:0]         q2;
      logic [REM_W-1:0]         rem1;
      logic [REM_W-1:0]         rem2;
   } div_type;

endpackage
`default_nettype wire

// ===== design/sliding_window_lifetime.sv =====
// Sliding window lifetime: for each event time, the first and last window holding it,
// birth, death and next window end times. Depends on swl_pkg, swl_div_stage, swl_post.
//
// An item is taken in every cycle that start is high; busy stays low. Each item yields one
// result, shown for one cycle with rsp_valid: registers form the dividends and their
// magnitudes, 65 one-bit division stages (one per quotient bit) produce both floor
// quotients, and post stages correct, combine and saturate. The receiver cannot stall, so
// nothing is held back. Write the window registers only while no item is in flight.
`default_nettype none
module sliding_window_lifetime #(
   parameter int TIME_BITS  = 64,
   parameter int INDEX_BITS = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic signed [swl_pkg::TIME_W-1:0]      req_event_time,
   output logic                                        rsp_valid,
   output logic                                        rsp_live,
   output logic signed [swl_pkg::IDX_OUT_W-1:0]        rsp_first_window,
   output logic signed [swl_pkg::IDX_OUT_W-1:0]        rsp_last_window,
   output logic signed [swl_pkg::TIME_W-1:0]           rsp_birth_time,
   output logic signed [swl_pkg::TIME_W-1:0]           rsp_death_time,
   output logic signed [swl_pkg::TIME_W-1:0]           rsp_next_slide_time,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [swl_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [swl_pkg::TIME_W-1:0]             csr_wdata
);
   localparam int MW = swl_pkg::MAG_W;
   localparam int DW = swl_pkg::DIFF_W;

   logic signed [swl_pkg::TIME_W-1:0] start_ff, start_in;
   logic [swl_pkg::RANGE_W-1:0]       range_ff, range_in, slide_ff, slide_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      start_in = start_ff;
      range_in = range_ff;
      slide_in = slide_ff;
      if (csr_valid) begin
         unique case (swl_pkg::csr_index_type'(csr_index))
            swl_pkg::CSR_START: start_in = csr_wdata;
            swl_pkg::CSR_RANGE: range_in = csr_wdata[swl_pkg::RANGE_W-1:0];
            swl_pkg::CSR_SLIDE: slide_in = (csr_wdata[swl_pkg::RANGE_W-1:0] == '0) ?
                                           62'd1 : csr_wdata[swl_pkg::RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         range_ff <= swl_pkg::RANGE_RESET;
         slide_ff <= swl_pkg::SLIDE_RESET;
      end else begin
         start_ff <= start_in;
         range_ff <= range_in;
         slide_ff <= slide_in;
      end
   end

   // dividends
   logic                              a_valid_ff;
   logic signed [swl_pkg::TIME_W-1:0] a_t_ff;
   logic signed [DW-1:0]              a_d1_ff, a_d2_ff, a_d1_in, a_d2_in;

   always_comb begin
      a_d2_in = DW'(req_event_time) - DW'(start_ff);
      a_d1_in = a_d2_in - $signed({4'd0, range_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
      a_t_ff  <= req_event_time;
      a_d1_ff <= a_d1_in;
      a_d2_ff <= a_d2_in;
   end

   // magnitudes
   swl_pkg::div_type chain [0:MW];
   swl_pkg::div_type b_ff, b_in;

   always_comb begin
      b_in.valid = a_valid_ff && !reset;
      b_in.t     = a_t_ff;
      b_in.neg1  = a_d1_ff[DW-1];
      b_in.neg2  = a_d2_ff[DW-1];
      b_in.mag1  = a_d1_ff[DW-1] ? MW'(-a_d1_ff) : a_d1_ff[MW-1:0];
      b_in.mag2  = a_d2_ff[DW-1] ? MW'(-a_d2_ff) : a_d2_ff[MW-1:0];
      b_in.q1    = '0;
      b_in.q2    = '0;
      b_in.rem1  = '0;
      b_in.rem2  = '0;
   end

   always_ff @(posedge clock) begin
      b_ff <= b_in;
   end

   assign chain[0] = b_ff;

   for (genvar k = 0; k < MW; k++) begin : g_div
      swl_div_stage #(
         .BIT (MW - 1 - k)
      ) u_stage (
         .clock (clock),
         .reset (reset),
         .slide (slide_ff),
         .d_in  (chain[k]),
         .d_out (chain[k+1])
      );
   end

   swl_post #(
      .TIME_BITS  (TIME_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_post (
      .clock               (clock),
      .reset               (reset),
      .d_in                (chain[MW]),
      .start               (start_ff),
      .range               (range_ff),
      .slide               (slide_ff),
      .rsp_valid           (rsp_valid),
      .rsp_live            (rsp_live),
      .rsp_first_window    (rsp_first_window),
      .rsp_last_window     (rsp_last_window),
      .rsp_birth_time      (rsp_birth_time),
      .rsp_death_time      (rsp_death_time),
      .rsp_next_slide_time (rsp_next_slide_time)
   );
endmodule
`default_nettype wire

// ===== design/swl_div_stage.sv =====
// One restoring division step for both quotient lanes, registered.
// Depends on swl_pkg.
`default_nettype none
module swl_div_stage #(
   parameter int BIT = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [swl_pkg::RANGE_W-1:0]   slide,
   input  wire swl_pkg::div_type              d_in,
   output swl_pkg::div_type                   d_out
);
   swl_pkg::div_type         step_ff;
   swl_pkg::div_type         step_in;
   logic [swl_pkg::REM_W:0]  sh1, sh2, den;
   logic                     ge1, ge2;

   always_comb begin
      den  = {1'b0, slide};
      sh1  = {d_in.rem1, d_in.mag1[BIT]};
      sh2  = {d_in.rem2, d_in.mag2[BIT]};
      ge1  = sh1 >= den;
      ge2  = sh2 >= den;
      step_in = d_in;
      step_in.valid = d_in.valid && !reset;
      step_in.q1[BIT] = ge1;
      step_in.q2[BIT] = ge2;
      step_in.rem1 = ge1 ? 62'(sh1 - den) : sh1[swl_pkg::REM_W-1:0];
      step_in.rem2 = ge2 ? 62'(sh2 - den) : sh2[swl_pkg::REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   assign d_out = step_ff;
endmodule
`default_nettype wire

// ===== design/swl_post.sv =====
// Floor correction, window arithmetic and saturation, three register stages.
// Depends on swl_pkg.
`default_nettype none
module swl_post #(
   parameter int TIME_BITS  = 64,
   parameter int INDEX_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire swl_pkg::div_type                     d_in,
   input  wire logic signed [swl_pkg::TIME_W-1:0]    start,
   input  wire logic [swl_pkg::RANGE_W-1:0]          range,
   input  wire logic [swl_pkg::RANGE_W-1:0]          slide,
   output logic                                      rsp_valid,
   output logic                                      rsp_live,
   output logic signed [swl_pkg::IDX_OUT_W-1:0]      rsp_first_window,
   output logic signed [swl_pkg::IDX_OUT_W-1:0]      rsp_last_window,
   output logic signed [swl_pkg::TIME_W-1:0]         rsp_birth_time,
   output logic signed [swl_pkg::TIME_W-1:0]         rsp_death_time,
   output logic signed [swl_pkg::TIME_W-1:0]         rsp_next_slide_time
);
   localparam int DW = swl_pkg::DIFF_W;
   localparam int WW = swl_pkg::WIDE_W;
   localparam logic signed [WW-1:0] TMAX = (67'sd1 <<< (TIME_BITS - 1)) - 67'sd1;
   localparam logic signed [WW-1:0] TMIN = -TMAX - 67'sd1;
   localparam logic signed [WW-1:0] IMAX = (67'sd1 <<< (INDEX_BITS - 1)) - 67'sd1;

   // stage 1: floor quotient and remainder
   logic                        p1_valid_ff;
   logic signed [swl_pkg::TIME_W-1:0] p1_t_ff;
   logic signed [DW-1:0]        p1_q1_ff, p1_q2_ff, p1_q1_in, p1_q2_in;
   logic [swl_pkg::REM_W-1:0]   p1_r1_ff, p1_r2_ff, p1_r1_in, p1_r2_in;

   always_comb begin
      if (d_in.neg1) begin
         p1_q1_in = (d_in.rem1 != '0) ? ~$signed({1'b0, d_in.q1}) : -$signed({1'b0, d_in.q1});
         p1_r1_in = (d_in.rem1 != '0) ? slide - d_in.rem1 : d_in.rem1;
      end else begin
         p1_q1_in = $signed({1'b0, d_in.q1});
         p1_r1_in = d_in.rem1;
      end
      if (d_in.neg2) begin
         p1_q2_in = (d_in.rem2 != '0) ? ~$signed({1'b0, d_in.q2}) : -$signed({1'b0, d_in.q2});
         p1_r2_in = (d_in.rem2 != '0) ? slide - d_in.rem2 : d_in.rem2;
      end else begin
         p1_q2_in = $signed({1'b0, d_in.q2});
         p1_r2_in = d_in.rem2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= d_in.valid;
      end
      p1_t_ff  <= d_in.t;
      p1_q1_ff <= p1_q1_in;
      p1_q2_ff <= p1_q2_in;
      p1_r1_ff <= p1_r1_in;
      p1_r2_ff <= p1_r2_in;
   end

   // stage 2: window bounds
   logic                 p2_valid_ff;
   logic signed [WW-1:0] p2_t_ff, p2_idx1_ff, p2_idx2_ff, p2_end_ff, p2_begin_ff, p2_death_ff;
   logic signed [WW-1:0] p2_idx1_in, p2_idx2_in, p2_end_in, p2_begin_in, p2_death_in;
   logic signed [WW-1:0] tw, sw, rgw, slw, r1w, r2w, q1w, q2w;
   logic                 before_one;

   always_comb begin
      tw  = WW'(p1_t_ff);
      sw  = WW'(start);
      rgw = $signed({5'd0, range});
      slw = $signed({5'd0, slide});
      r1w = $signed({5'd0, p1_r1_ff});
      r2w = $signed({5'd0, p1_r2_ff});
      q1w = WW'(p1_q1_ff);
      q2w = WW'(p1_q2_ff);
      before_one = q1w < -67'sd1;
      if (before_one) begin
         p2_idx1_in  = 67'sd1;
         p2_end_in   = sw + rgw;
         p2_begin_in = sw;
      end else begin
         p2_idx1_in  = q1w + 67'sd2;
         p2_end_in   = tw - r1w + slw;
         p2_begin_in = tw - r1w + slw - rgw;
      end
      p2_idx2_in  = q2w + 67'sd1;
      p2_death_in = tw - r2w + slw + rgw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
      p2_t_ff     <= tw;
      p2_idx1_ff  <= p2_idx1_in;
      p2_idx2_ff  <= p2_idx2_in;
      p2_end_ff   <= p2_end_in;
      p2_begin_ff <= p2_begin_in;
      p2_death_ff <= p2_death_in;
   end

   // stage 3: liveness and saturation into the output register
   logic                 live;
   logic signed [WW-1:0] end_sat, death_sat, idx1_sat, idx2_sat;
   logic                 out_valid_ff, out_live_ff;
   logic signed [swl_pkg::IDX_OUT_W-1:0] out_first_ff, out_last_ff, out_first_in, out_last_in;
   logic signed [swl_pkg::TIME_W-1:0]    out_birth_ff, out_death_ff, out_next_ff;
   logic signed [swl_pkg::TIME_W-1:0]    out_birth_in, out_death_in;

   always_comb begin
      live      = p2_t_ff >= p2_begin_ff;
      end_sat   = (p2_end_ff > TMAX) ? TMAX : ((p2_end_ff < TMIN) ? TMIN : p2_end_ff);
      death_sat = (p2_death_ff > TMAX) ? TMAX : ((p2_death_ff < TMIN) ? TMIN : p2_death_ff);
      idx1_sat  = (p2_idx1_ff > IMAX) ? IMAX : p2_idx1_ff;
      idx2_sat  = (p2_idx2_ff > IMAX) ? IMAX : p2_idx2_ff;
      if (live) begin
         out_first_in = idx1_sat[swl_pkg::IDX_OUT_W-1:0];
         out_last_in  = idx2_sat[swl_pkg::IDX_OUT_W-1:0];
         out_birth_in = end_sat[swl_pkg::TIME_W-1:0];
         out_death_in = death_sat[swl_pkg::TIME_W-1:0];
      end else begin
         out_first_in = '1;
         out_last_in  = '1;
         out_birth_in = TMAX[swl_pkg::TIME_W-1:0];
         out_death_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= p2_valid_ff;
      end
      out_live_ff  <= live;
      out_first_ff <= out_first_in;
      out_last_ff  <= out_last_in;
      out_birth_ff <= out_birth_in;
      out_death_ff <= out_death_in;
      out_next_ff  <= end_sat[swl_pkg::TIME_W-1:0];
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_live            = out_live_ff;
   assign rsp_first_window    = out_first_ff;
   assign rsp_last_window     = out_last_ff;
   assign rsp_birth_time      = out_birth_ff;
   assign rsp_death_time      = out_death_ff;
   assign rsp_next_slide_time = out_next_ff;
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for sliding_window_lifetime: drives event times and window settings,
// predicts every result with exact wide floor division and compares field by field.
// Depends on swl_pkg and the sliding_window_lifetime RTL.
`default_nettype none
module tb_top;

   localparam logic signed [63:0] TMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] TMIN = 64'sh8000_0000_0000_0000;
   localparam logic [61:0] RMAX = {62{1'b1}};
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic               live;
      logic signed [31:0] first_window;
      logic signed [31:0] last_window;
      logic signed [63:0] birth_time;
      logic signed [63:0] death_time;
      logic signed [63:0] next_slide_time;
   } lifetime_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [63:0] req_event_time = '0;
   logic rsp_valid, rsp_live;
   logic signed [31:0] rsp_first_window, rsp_last_window;
   logic signed [63:0] rsp_birth_time, rsp_death_time, rsp_next_slide_time;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [swl_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   logic signed [63:0] win_start;
   logic [61:0] win_range, win_slide;
   lifetime_type lifetime_q[$];
   int fails = 0;
   bit quiet = 0;

   sliding_window_lifetime DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_event_time(req_event_time),
      .rsp_valid(rsp_valid), .rsp_live(rsp_live),
      .rsp_first_window(rsp_first_window), .rsp_last_window(rsp_last_window),
      .rsp_birth_time(rsp_birth_time), .rsp_death_time(rsp_death_time),
      .rsp_next_slide_time(rsp_next_slide_time),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void floor_div(input logic signed [129:0] num, input logic [61:0] den,
                                     output logic signed [129:0] quo,
                                     output logic signed [129:0] rem);
      logic signed [129:0] d;
      d = $signed({68'd0, den});
      quo = num / d;
      rem = num % d;
      if (rem < 0) begin
         quo = quo - 130'sd1;
         rem = rem + d;
      end
   endfunction

   function automatic logic signed [63:0] clamp_time(input logic signed [129:0] v);
      if (v > $signed({{66{1'b0}}, TMAX})) return TMAX;
      if (v < $signed({{66{1'b1}}, TMIN})) return TMIN;
      return v[63:0];
   endfunction

   function automatic logic signed [31:0] clamp_index(input logic signed [129:0] v);
      if (v > 130'sd2147483647) return 32'sd2147483647;
      return v[31:0];
   endfunction

   function automatic lifetime_type window_lifetime(input logic signed [63:0] t64);
      logic signed [129:0] t, s, rg, sl, q1, r1, q2, r2, idx, win_end, win_begin, death;
      lifetime_type res;
      t = 130'(t64);
      s = 130'(win_start);
      rg = $signed({68'd0, win_range});
      sl = $signed({68'd0, (win_slide == 62'd0) ? 62'd1 : win_slide});
      floor_div(t - s - rg, sl[61:0], q1, r1);
      if (q1 < -130'sd1) begin
         idx = 130'sd1;
         win_end = s + rg;
         win_begin = s;
      end else begin
         idx = q1 + 130'sd2;
         win_end = t - r1 + sl;
         win_begin = win_end - rg;
      end
      floor_div(t - s, sl[61:0], q2, r2);
      death = t - r2 + sl + rg;
      res.live = (t >= win_begin);
      res.next_slide_time = clamp_time(win_end);
      if (res.live) begin
         res.first_window = clamp_index(idx);
         res.last_window = clamp_index(q2 + 130'sd1);
         res.birth_time = clamp_time(win_end);
         res.death_time = clamp_time(death);
      end else begin
         res.first_window = -32'sd1;
         res.last_window = -32'sd1;
         res.birth_time = TMAX;
         res.death_time = 64'sd0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (lifetime_q.size() == 0) begin
            $error("result with no item outstanding");
            fails++;
         end else begin
            lifetime_type e;
            e = lifetime_q.pop_front();
            if (rsp_live !== e.live) begin
               $error("live exp %0d got %0d", e.live, rsp_live); fails++;
            end
            if (rsp_first_window !== e.first_window) begin
               $error("first_window exp %0d got %0d", e.first_window, rsp_first_window);
               fails++;
            end
            if (rsp_last_window !== e.last_window) begin
               $error("last_window exp %0d got %0d", e.last_window, rsp_last_window);
               fails++;
            end
            if (rsp_birth_time !== e.birth_time) begin
               $error("birth_time exp %0d got %0d", e.birth_time, rsp_birth_time); fails++;
            end
            if (rsp_death_time !== e.death_time) begin
               $error("death_time exp %0d got %0d", e.death_time, rsp_death_time); fails++;
            end
            if (rsp_next_slide_time !== e.next_slide_time) begin
               $error("next_slide_time exp %0d got %0d", e.next_slide_time,
                      rsp_next_slide_time);
               fails++;
            end
         end
      end
   end

   task automatic send_event(input logic signed [63:0] t);
      @(negedge clock);
      if (!quiet && $urandom_range(5, 0) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(11, 1)) @(negedge clock);
      end
      start <= 1'b1;
      req_event_time <= t;
      do @(posedge clock); while (busy);
      lifetime_q.push_back(window_lifetime(t));
   endtask

   task automatic drain;
      @(negedge clock);
      start <= 1'b0;
      while (lifetime_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input swl_pkg::csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      if (!quiet && $urandom_range(3, 0) == 0) repeat ($urandom_range(11, 1)) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         swl_pkg::CSR_START: win_start = value;
         swl_pkg::CSR_RANGE: win_range = value[61:0];
         swl_pkg::CSR_SLIDE: win_slide = value[61:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_windows(input logic signed [63:0] s, input logic [63:0] rg,
                              input logic [63:0] sl);
      drain();
      write_csr(swl_pkg::CSR_START, s);
      write_csr(swl_pkg::CSR_RANGE, rg);
      write_csr(swl_pkg::CSR_SLIDE, sl);
   endtask

   function automatic logic signed [63:0] random_event();
      logic [63:0] off;
      off = {$urandom, $urandom} >> $urandom_range(63, 0);
      if ($urandom_range(1, 0)) off = -off;
      case ($urandom_range(3, 0))
         0: return {$urandom, $urandom};
         1: return win_start + off;
         2: return win_start + win_range + off;
         default: return win_start + 64'(win_slide) * $urandom_range(5, 0) + off[15:0] - 5;
      endcase
   endfunction

   task automatic random_events(input int n);
      repeat (n) send_event(random_event());
   endtask

   task automatic edge_events;
      logic signed [63:0] s;
      s = win_start;
      send_event(TMIN);
      send_event(TMAX);
      send_event(64'sd0);
      send_event(-64'sd1);
      send_event(s - 1);
      send_event(s);
      send_event(s + win_range - 1);
      send_event(s + win_range);
      send_event(s + win_slide);
      send_event(s + win_slide - 1);
   endtask

   task automatic test_reset_defaults;
      win_start = 64'sd0;
      win_range = swl_pkg::RANGE_RESET;
      win_slide = swl_pkg::SLIDE_RESET;
      edge_events();
      random_events(40);
   endtask

   task automatic test_special_cases;
      set_windows(64'sd0, 64'd0, 64'd10);
      edge_events();
      set_windows(-64'sd5, 64'd7, 64'd0);
      edge_events();
      set_windows(TMIN, 64'(RMAX), 64'(RMAX));
      edge_events();
      set_windows(TMAX, 64'd1, 64'd1);
      edge_events();
      set_windows(64'sd100, 64'hC000_0000_0000_0010, 64'hC000_0000_0000_0004);
      edge_events();
      set_windows(64'sd0, 64'd1, 64'd1);
      send_event(TMAX);
      send_event(64'sd4294967296);
   endtask

   task automatic test_random_windows;
      repeat (6) begin
         logic [61:0] rg, sl;
         rg = $urandom_range(3, 0) == 0 ? 62'({$urandom, $urandom}) :
                                          62'($urandom_range(40, 1));
         sl = $urandom_range(3, 0) == 0 ? 62'({$urandom, $urandom}) :
                                          62'($urandom_range(15, 1));
         set_windows({$urandom, $urandom},
                     ({$urandom, $urandom} & 64'hC000_0000_0000_0000) | {2'b00, rg},
                     {2'b00, sl});
         random_events(95);
      end
   endtask

   task automatic test_pause;
      set_windows(-64'sd1000, 64'd25, 64'd10);
      random_events(60);
      @(negedge clock);
      start <= 1'b0;
      while (lifetime_q.size() != 0) @(posedge clock);
      random_events(60);
   endtask

   task automatic test_back_to_back;
      set_windows(64'sd12345, 64'd3000, 64'd1000);
      quiet = 1;
      random_events(120);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_special_cases();
      test_random_windows();
      test_pause();
      test_back_to_back();
      drain();
      if (fails == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
